@@ rtl/b32crc_pkg.sv @@
// Shared types, codes and helper functions for the base32 / CRC-32 frame encoder.
// No dependencies.
package b32crc_pkg;

    // Section codes carried with each output character
    localparam logic [1:0] SECT_BODY = 2'd0;
    localparam logic [1:0] SECT_DOT  = 2'd1;
    localparam logic [1:0] SECT_CRC  = 2'd2;

    localparam logic [6:0]  CHAR_DOT   = 7'h2e;
    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_PRESET = 32'hffffffff;

    // Frame byte counter width (payload limit range 1..511)
    localparam int BYTE_CNT_W = 9;

    typedef struct packed {
        logic [6:0] out_char;
        logic [1:0] section;
        logic       frame_end;
        logic       overflow_error;
    } t_result;

    // One byte through the reflected CRC-32, bitwise
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // RFC 4648 base32 alphabet: A-Z then 2-7
    function automatic logic [6:0] b32_char(input logic [4:0] sym);
        return (sym < 5'd26) ? (7'h41 + {2'b00, sym}) : (7'h18 + {2'b00, sym});
    endfunction

endpackage

@@ rtl/base32_crc32_frame_encoder.sv @@
// Top level: streaming base32 encoder with '.' separator and base32 CRC-32 trailer.
// Depends on b32crc_pkg (types, section codes, CRC and alphabet functions).
//
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+---------------------------------------
// in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
// out     | output    | o_out_valid / i_out_ready | o_out_char, o_section, o_frame_end,
//         |           |                           | o_overflow_error
//
// A byte request updates CRC and bit buffer in the accepting cycle and loads a job
// register; the emitter sends one character per cycle into the output register unless
// the output stalls. A body byte owes 1 or 2 characters (about 1.6 on average);
// a last byte owes up to 11 (body, flush, dot, seven CRC characters).
// A dropped non-last byte loads no job and produces nothing.
// Synchronous active-low reset clears frame state, job and output valid.
// Output stalls back up through the job register to o_in_ready.
module base32_crc32_frame_encoder #(
    parameter int MAX_PAYLOAD = 320
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_out_char,
    output logic [1:0] o_section,
    output logic       o_frame_end,
    output logic       o_overflow_error
);
    import b32crc_pkg::*;

    // Frame state
    logic [3:0]            r_bit_buf;
    logic [2:0]            r_bit_cnt;
    logic [31:0]           r_crc;
    logic [BYTE_CNT_W-1:0] r_byte_cnt;
    logic                  r_ovf;

    // Job register: results still owed for the last accepted byte
    logic        r_job_valid;
    logic [4:0]  r_sym0, r_sym1, r_flush_sym;
    logic [1:0]  r_nbody;
    logic        r_err, r_has_flush;
    logic [31:0] r_crc_out;
    logic [3:0]  r_total, r_idx;

    // Output register
    logic    r_out_valid;
    t_result r_out;

    // Input side computation
    logic        accept, drop;
    logic [11:0] cat;
    logic [3:0]  cnt, sh0, sh1;
    logic        two;
    logic [4:0]  n_sym0, n_sym1, n_flush_sym, rem_mask;
    logic [2:0]  rem_cnt;
    logic [3:0]  rem_bits;
    logic [31:0] n_crc;
    logic [1:0]  n_nbody;
    logic        n_ovf, n_err, n_has_flush;
    logic [3:0]  n_total;

    // Emitter
    logic        adv, job_last;
    logic [3:0]  j, k, m;
    t_result     n_out;

    assign drop   = r_byte_cnt >= BYTE_CNT_W'(MAX_PAYLOAD);
    assign accept = i_in_valid && o_in_ready;

    // Bit buffer split into base32 symbols
    always_comb begin
        cat = {r_bit_buf, i_data_byte};
        cnt = {1'b0, r_bit_cnt} + 4'd8;
        two = cnt >= 4'd10;
        sh0 = cnt - 4'd5;
        sh1 = cnt - 4'd10;
        n_sym0 = 5'(cat >> sh0);
        n_sym1 = 5'(cat >> sh1);
        if (drop) begin
            n_crc    = r_crc;
            n_nbody  = 2'd0;
            rem_cnt  = r_bit_cnt;
            rem_mask = 5'd0;
            rem_bits = r_bit_buf;
        end else begin
            n_crc    = crc_byte(r_crc, i_data_byte);
            n_nbody  = two ? 2'd2 : 2'd1;
            rem_cnt  = two ? 3'(sh1) : 3'(sh0);
            rem_mask = (5'd1 << rem_cnt) - 5'd1;
            rem_bits = cat[3:0] & rem_mask[3:0];
        end
        n_flush_sym = 5'({1'b0, rem_bits} << (3'd5 - rem_cnt));
        n_ovf       = r_ovf || drop;
        n_err       = i_last_byte && n_ovf;
        n_has_flush = rem_cnt != 3'd0;
        n_total     = {2'b00, n_nbody};
        if (i_last_byte) begin
            n_total = n_ovf ? n_total + 4'd1
                            : n_total + 4'd8 + {3'd0, n_has_flush};
        end
    end

    // Handshake control
    assign job_last   = r_idx == (r_total - 4'd1);
    assign adv        = r_job_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_job_valid || (adv && job_last);

    // Result selection for the current job slot
    always_comb begin
        j = r_idx - {2'b00, r_nbody};
        k = j - {3'd0, r_has_flush};
        m = k - 4'd1;
        n_out = '{out_char: 7'd0, section: SECT_BODY, frame_end: 1'b0, overflow_error: 1'b0};
        if (r_idx < {2'b00, r_nbody}) begin
            n_out.out_char = b32_char((r_idx == 4'd0) ? r_sym0 : r_sym1);
        end else if (r_err) begin
            n_out.frame_end      = 1'b1;
            n_out.overflow_error = 1'b1;
        end else if (r_has_flush && j == 4'd0) begin
            n_out.out_char = b32_char(r_flush_sym);
        end else if (k == 4'd0) begin
            n_out.out_char = CHAR_DOT;
            n_out.section  = SECT_DOT;
        end else begin
            n_out.section = SECT_CRC;
            case (m)
                4'd0:    n_out.out_char = b32_char(r_crc_out[31:27]);
                4'd1:    n_out.out_char = b32_char(r_crc_out[26:22]);
                4'd2:    n_out.out_char = b32_char(r_crc_out[21:17]);
                4'd3:    n_out.out_char = b32_char(r_crc_out[16:12]);
                4'd4:    n_out.out_char = b32_char(r_crc_out[11:7]);
                4'd5:    n_out.out_char = b32_char(r_crc_out[6:2]);
                default: begin
                    n_out.out_char  = b32_char({r_crc_out[1:0], 3'b000});
                    n_out.frame_end = 1'b1;
                end
            endcase
        end
    end

    // Frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_buf  <= '0;
            r_bit_cnt  <= '0;
            r_crc      <= CRC_PRESET;
            r_byte_cnt <= '0;
            r_ovf      <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_bit_buf  <= '0;
                r_bit_cnt  <= '0;
                r_crc      <= CRC_PRESET;
                r_byte_cnt <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_bit_buf  <= rem_bits;
                r_bit_cnt  <= rem_cnt;
                r_crc      <= n_crc;
                r_byte_cnt <= drop ? r_byte_cnt : r_byte_cnt + BYTE_CNT_W'(1);
                r_ovf      <= n_ovf;
            end
        end
    end

    // Job register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (accept) begin
            r_job_valid <= n_total != 4'd0;
        end else if (adv && job_last) begin
            r_job_valid <= 1'b0;
        end
    end

    // Job payload and slot index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sym0      <= n_sym0;
            r_sym1      <= n_sym1;
            r_flush_sym <= n_flush_sym;
            r_nbody     <= n_nbody;
            r_err       <= n_err;
            r_has_flush <= n_has_flush;
            r_crc_out   <= ~n_crc;
            r_total     <= n_total;
            r_idx       <= '0;
        end else if (adv) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out.out_char;
    assign o_section        = r_out.section;
    assign o_frame_end      = r_out.frame_end;
    assign o_overflow_error = r_out.overflow_error;

`ifndef SYNTHESIS
    // Slot index stays inside the job
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx < r_total))
        else $error("job slot index beyond job length");

    // A new request only replaces a job that finishes this cycle
    a_no_job_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_job_valid) |-> (adv && job_last))
        else $error("job overwritten before completion");

    // Error results always end the frame with a null character
    a_err_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error) |-> (o_frame_end && o_out_char == 7'd0))
        else $error("overflow result not a frame end");

    // Normal frame end is the last checksum character
    a_end_is_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end && !o_overflow_error) |-> (o_section == SECT_CRC))
        else $error("frame end outside checksum");

    // Last byte returns the frame state to its reset values
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_byte_cnt == '0 && r_bit_cnt == '0 && !r_ovf
                                     && r_crc == CRC_PRESET))
        else $error("frame state not cleared after last byte");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for base32_crc32_frame_encoder: directed frames from a table,
// then random frames under several idle/stall mixes, checked against a local predictor.
// Depends on b32crc_pkg (t_result, section codes, CRC polynomial) and the encoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b32crc_pkg::*;

    localparam int MAX_PAYLOAD = 320;
    localparam int RAND_ITEMS  = 170;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [6:0] CH_A = 7'h41;
    localparam logic [6:0] CH_7 = 7'h37;
    localparam logic [8*32-1:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    localparam t_result NO_CHAR    = '0;
    localparam t_result OVF_RESULT = '{7'd0, SECT_BODY, 1'b1, 1'b1};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One table entry: byte (incremented per repeat), last flag, repeat count,
    // and optionally a hand-typed single result instead of the predicted one
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [8:0] reps;
        logic       typed;
        t_result    want;
    } t_frame_row;

    localparam int PLAN_LEN = 19;
    localparam t_frame_row PLAN [PLAN_LEN] = '{
        '{8'h00, 1'b0, 9'd1,   1'b1, '{CH_A, SECT_BODY, 1'b0, 1'b0}}, // zero byte after reset
        '{8'h00, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 2-byte frame, 1-bit flush
        '{8'hff, 1'b0, 9'd1,   1'b1, '{CH_7, SECT_BODY, 1'b0, 1'b0}}, // all-ones byte
        '{8'hff, 1'b1, 9'd1,   1'b0, NO_CHAR},
        '{8'hff, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 1-byte frame, 3-bit flush
        '{8'h80, 1'b0, 9'd1,   1'b0, NO_CHAR},
        '{8'h01, 1'b0, 9'd1,   1'b0, NO_CHAR},
        '{8'haa, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 3-byte frame, 4-bit flush
        '{8'h55, 1'b0, 9'd3,   1'b0, NO_CHAR},
        '{8'h0f, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 4-byte frame, 2-bit flush
        '{8'h00, 1'b0, 9'd4,   1'b0, NO_CHAR},
        '{8'h00, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 5-byte frame, no flush
        '{8'hff, 1'b0, 9'd4,   1'b0, NO_CHAR},
        '{8'hff, 1'b1, 9'd1,   1'b0, NO_CHAR},                        // 5-byte frame, no flush
        '{8'h20, 1'b0, 9'd320, 1'b0, NO_CHAR},                        // payload filled
        '{8'h7e, 1'b0, 9'd2,   1'b0, NO_CHAR},                        // dropped, nothing out
        '{8'h00, 1'b1, 9'd1,   1'b1, OVF_RESULT},                     // overflowed frame ends
        '{8'h00, 1'b0, 9'd1,   1'b1, '{CH_A, SECT_BODY, 1'b0, 1'b0}}, // state cleared again
        '{8'h3c, 1'b1, 9'd1,   1'b0, NO_CHAR}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [6:0] o_out_char;
    logic [1:0] o_section;
    logic       o_frame_end;
    logic       o_overflow_error;

    // Predictor state for the frame in progress
    logic [11:0] enc_bits;
    logic [3:0]  enc_nbits;
    logic [31:0] enc_crc;
    logic [8:0]  enc_nbytes;
    logic        enc_ovf;

    t_result new_chars[$];
    t_result expected_chars[$];

    int send_idle_pct;
    int recv_stall_pct;
    int rand_items;
    int fails;
    int unsigned cycles;

    base32_crc32_frame_encoder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_char      (o_out_char),
        .o_section       (o_section),
        .o_frame_end     (o_frame_end),
        .o_overflow_error(o_overflow_error)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_encoder();
        enc_bits   = '0;
        enc_nbits  = '0;
        enc_crc    = CRC_PRESET;
        enc_nbytes = '0;
        enc_ovf    = 1'b0;
    endfunction

    function automatic t_result sym_result(input logic [4:0] sym, input logic [1:0] sect,
                                           input logic last);
        t_result r;
        r.out_char       = B32_ALPHABET[8*(31 - int'(sym)) +: 7];
        r.section        = sect;
        r.frame_end      = last;
        r.overflow_error = 1'b0;
        return r;
    endfunction

    // Expected characters for one accepted byte, appended to new_chars
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic [31:0] c;
        logic [31:0] sig;
        t_result     dot;
        if (enc_nbytes >= MAX_PAYLOAD) begin
            enc_ovf = 1'b1;
        end else begin
            enc_nbytes = enc_nbytes + 9'd1;
            c = enc_crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
            end
            enc_crc   = c;
            enc_bits  = {enc_bits[3:0], b};
            enc_nbits = enc_nbits + 4'd8;
            while (enc_nbits >= 5) begin
                new_chars.push_back(sym_result(5'(enc_bits >> (enc_nbits - 5)), SECT_BODY, 1'b0));
                enc_nbits = enc_nbits - 4'd5;
            end
            enc_bits = enc_bits & ((12'd1 << enc_nbits) - 12'd1);
        end

        if (last) begin
            if (enc_ovf) begin
                new_chars.push_back(OVF_RESULT);
            end else begin
                sig = ~enc_crc;
                // leftover bits, zero-filled on the right
                if (enc_nbits > 0) begin
                    new_chars.push_back(sym_result(5'(enc_bits << (5 - enc_nbits)), SECT_BODY,
                                                   1'b0));
                end
                dot = '{CHAR_DOT, SECT_DOT, 1'b0, 1'b0};
                new_chars.push_back(dot);
                for (int i = 0; i < 6; i++) begin
                    new_chars.push_back(sym_result(5'(sig >> (27 - 5 * i)), SECT_CRC, 1'b0));
                end
                new_chars.push_back(sym_result({sig[1:0], 3'b000}, SECT_CRC, 1'b1));
            end
            clear_encoder();
        end
    endfunction

    function automatic void set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            default: begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase
    endfunction

    // Present one byte request from a falling edge, wait for acceptance, predict.
    // Returns at the following falling edge with valid still high.
    task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        new_chars.delete();
        encode_byte(b, last);
        if (typed) begin
            expected_chars.push_back(want);
        end else begin
            foreach (new_chars[k]) expected_chars.push_back(new_chars[k]);
        end
        @(negedge i_clk);
    endtask

    // Receiver back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected char: out_char %h section %0d frame_end %b overflow_error %b",
                       o_out_char, o_section, o_frame_end, o_overflow_error);
                fails++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, o_out_char);
                    fails++;
                end
                if (o_section !== want.section) begin
                    $error("section: expected %0d, got %0d", want.section, o_section);
                    fails++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end, o_frame_end);
                    fails++;
                end
                if (o_overflow_error !== want.overflow_error) begin
                    $error("overflow_error: expected %b, got %b", want.overflow_error,
                           o_overflow_error);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int len;
        fails      = 0;
        rand_items = 0;
        cycles     = 0;
        clear_encoder();
        set_idle(IDLE_BOTH);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames
        for (int r = 0; r < PLAN_LEN; r++) begin
            for (int j = 0; j < int'(PLAN[r].reps); j++) begin
                push_byte(PLAN[r].data + 8'(j), PLAN[r].last, PLAN[r].typed, PLAN[r].want);
            end
        end

        // Random frames; idle mix steps through the four modes as bytes go by
        while (rand_items < RAND_ITEMS) begin
            set_idle(t_idle_mode'(rand_items * 4 / RAND_ITEMS));
            if ($urandom_range(9) < 7) begin
                len = $urandom_range(1, 8);
            end else begin
                len = $urandom_range(9, 40);
            end
            for (int j = 0; j < len; j++) begin
                if (enc_nbytes < MAX_PAYLOAD) rand_items++;
                push_byte(8'($urandom_range(0, 255)), j == len - 1, 1'b0, NO_CHAR);
            end
        end
        i_in_valid = 1'b0;

        // Drain, then watch for stray characters
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/b32crc_pkg.sv
rtl/base32_crc32_frame_encoder.sv
dv/testbench.sv
